@@ src/jsfx_pkg.sv @@
// ----------------------------------------------------------------------------
// jsfx_pkg: shared types and constants of the JSON string field extractor
// Character codes, parser phases, result beat layout and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package jsfx_pkg;

  localparam int KEY_MAX_DEF = 8;   // default longest key
  localparam int CHAR_W      = 8;
  localparam int KEY_W       = 64;  // packed key register
  localparam int KEY_BYTES   = KEY_W / CHAR_W;
  localparam int KEY_LEN_W   = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int STATUS_W    = 2;
  localparam int MAX_RES     = 3;   // most beats one character can cause
  localparam int OQ_DEPTH    = 4;   // output queue slots
  localparam int OQ_CNT_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_CHARS  = 1'b0,
    CFG_KEY_LENGTH = 1'b1
  } cfg_idx_e;

  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LOWER_N = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LOWER_T = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LOWER_R = 8'h72;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNTERM    = 2'd3;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SEP1,
    PH_SEP2,
    PH_VALUE,
    PH_ESC,
    PH_BAD,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic                item_kind;
    logic [CHAR_W-1:0]   value_char;
    logic [STATUS_W-1:0] status;
    logic                is_final;
  } res_t;

  // Result beats caused by one accepted character.
  typedef struct packed {
    logic [1:0]              count;
    res_t [MAX_RES-1:0]      item;
  } batch_t;

  function automatic res_t mk_value(input logic [CHAR_W-1:0] ch);
    res_t r;
    r.item_kind  = KIND_VALUE;
    r.value_char = ch;
    r.status     = ST_FOUND;
    r.is_final   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [STATUS_W-1:0] st, input logic fin);
    res_t r;
    r.item_kind  = KIND_STATUS;
    r.value_char = '0;
    r.status     = st;
    r.is_final   = fin;
    return r;
  endfunction

  function automatic logic is_ws(input logic [CHAR_W-1:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
  endfunction

endpackage

`default_nettype wire

@@ src/jsfx_in_if.sv @@
// ----------------------------------------------------------------------------
// jsfx_in_if: body character channel
// One beat carries one text character and the end-of-body flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsfx_in_if;
  logic                       valid;
  logic                       ready;
  logic [jsfx_pkg::CHAR_W-1:0] text_char;
  logic                       end_of_body;

  modport source (output valid, output text_char, output end_of_body, input ready);
  modport sink   (input valid, input text_char, input end_of_body, output ready);
endinterface

`default_nettype wire

@@ src/jsfx_out_if.sv @@
// ----------------------------------------------------------------------------
// jsfx_out_if: result channel
// One beat carries either a decoded value character or a status.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsfx_out_if;
  logic                          valid;
  logic                          ready;
  logic                          item_kind;
  logic [jsfx_pkg::CHAR_W-1:0]   value_char;
  logic [jsfx_pkg::STATUS_W-1:0] status;
  logic                          is_final;

  modport source (output valid, output item_kind, output value_char, output status,
                  output is_final, input ready);
  modport sink   (input valid, input item_kind, input value_char, input status,
                  input is_final, output ready);
endinterface

`default_nettype wire

@@ src/json_string_field_extractor_core.sv @@
// ----------------------------------------------------------------------------
// json_string_field_extractor_core: streaming JSON string field extractor
// Finds "key" in a character stream and emits the decoded string value.
// ----------------------------------------------------------------------------
// Takes one body character per beat on in_ch (end_of_body marks the last one)
// and returns beats on out_ch: decoded value characters (item_kind 0), then a
// status beat (item_kind 1). Every body ends with exactly one status beat with
// is_final set; when that status is not found, the value beats already sent
// for the body are to be dropped downstream. A closing quote before the body
// end gives an early found status with is_final clear. One character is taken
// per clock while out_ch keeps up; a character that causes two or three beats
// (an unknown escape, or a value character or escape that is also the last
// character of the body) holds in_ch while the four-slot output queue drains
// the extra beats. The user must make configuration writes only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_field_extractor_core #(
  parameter int KEY_MAX = jsfx_pkg::KEY_MAX_DEF  // 1..16, longest key matched
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jsfx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jsfx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  jsfx_in_if.sink                         in_ch,
  jsfx_out_if.source                      out_ch
);
  import jsfx_pkg::*;

  logic [KEY_W-1:0]     key_chars_q;
  logic [KEY_LEN_W-1:0] key_length_q;
  logic                 accept;
  logic                 room;
  batch_t               batch;
  res_t                 head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars_q  <= '0;
      key_length_q <= KEY_LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_CHARS:  key_chars_q  <= cfg_wdata_i[KEY_W-1:0];
        CFG_KEY_LENGTH: key_length_q <= cfg_wdata_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side only waits on queue space, never on out_ch.ready directly
  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  jsfx_scan #(
    .KEY_MAX(KEY_MAX)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_chars_i  (key_chars_q),
    .key_length_i (key_length_q),
    .accept_i     (accept),
    .text_char_i  (in_ch.text_char),
    .end_of_body_i(in_ch.end_of_body),
    .batch_o      (batch)
  );

  jsfx_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .batch_i(batch),
    .room_o (room),
    .valid_o(out_ch.valid),
    .ready_i(out_ch.ready),
    .data_o (head)
  );

  assign out_ch.item_kind  = head.item_kind;
  assign out_ch.value_char = head.value_char;
  assign out_ch.status     = head.status;
  assign out_ch.is_final   = head.is_final;

endmodule

`default_nettype wire

@@ src/jsfx_scan.sv @@
// ----------------------------------------------------------------------------
// jsfx_scan: key search and value parser
// Needle match over a character shift line, separator check, escape decode.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfx_scan #(
  parameter int KEY_MAX = jsfx_pkg::KEY_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [jsfx_pkg::KEY_W-1:0]     key_chars_i,
  input  logic [jsfx_pkg::KEY_LEN_W-1:0] key_length_i,
  input  logic                           accept_i,
  input  logic [jsfx_pkg::CHAR_W-1:0]    text_char_i,
  input  logic                           end_of_body_i,
  output jsfx_pkg::batch_t               batch_o
);
  import jsfx_pkg::*;

  localparam int DEPTH  = KEY_MAX + 2;
  localparam int SEEN_W = $clog2(DEPTH + 1);
  localparam int NLEN_W = $clog2(KEY_MAX + 1);

  phase_e                       phase_q, phase_d;
  logic [DEPTH-1:0][CHAR_W-1:0] recent_q, recent_d, recent_sh;
  logic [SEEN_W-1:0]            seen_q, seen_d, seen_inc;
  logic [KEY_MAX-1:0][CHAR_W-1:0] key_arr;
  logic [KEY_MAX:0]             len_match;
  logic [NLEN_W-1:0]            n_eff;
  logic                         needle_hit;
  logic [1:0]                   n;

  // Shifted line, newest character in slot 0
  always_comb begin
    recent_sh[0] = text_char_i;
    for (int k = 1; k < DEPTH; k++) begin
      recent_sh[k] = recent_q[k-1];
    end
    seen_inc = (seen_q < SEEN_W'(DEPTH)) ? seen_q + SEEN_W'(1) : seen_q;
  end

  // Key bytes past the register width read as zero
  always_comb begin
    for (int m = 0; m < KEY_MAX; m++) begin
      key_arr[m] = (m < KEY_BYTES) ? key_chars_i[(m % KEY_BYTES)*CHAR_W +: CHAR_W] : '0;
    end
  end

  // One match term per key length, then pick the configured one
  always_comb begin
    for (int ln = 0; ln <= KEY_MAX; ln++) begin
      len_match[ln] = (seen_inc >= SEEN_W'(ln + 2)) && (recent_sh[0] == CH_QUOTE) &&
                      (recent_sh[ln+1] == CH_QUOTE);
      for (int m = 0; m < ln; m++) begin
        if (recent_sh[ln-m] != key_arr[m]) begin
          len_match[ln] = 1'b0;
        end
      end
    end
    if (int'(key_length_i) > KEY_MAX) begin
      n_eff = NLEN_W'(KEY_MAX);
    end else begin
      n_eff = NLEN_W'(key_length_i);
    end
    needle_hit = len_match[n_eff];
  end

  always_comb begin
    phase_d  = phase_q;
    recent_d = recent_q;
    seen_d   = seen_q;
    batch_o  = '0;
    n        = 2'd0;
    case (phase_q)
      PH_SEARCH: begin
        recent_d = recent_sh;
        seen_d   = seen_inc;
        if (needle_hit) phase_d = PH_SEP1;
      end
      PH_SEP1: begin
        if (text_char_i == CH_COLON) phase_d = PH_SEP2;
        else if (!is_ws(text_char_i)) phase_d = PH_BAD;
      end
      PH_SEP2: begin
        if (text_char_i == CH_QUOTE) phase_d = PH_VALUE;
        else if (!is_ws(text_char_i)) phase_d = PH_BAD;
      end
      PH_VALUE: begin
        if (text_char_i == CH_BSLASH) begin
          if (!end_of_body_i) phase_d = PH_ESC;
        end else if (text_char_i == CH_QUOTE) begin
          phase_d = PH_DONE;
          if (!end_of_body_i) begin
            batch_o.item[n] = mk_status(ST_FOUND, 1'b0);
            n = n + 2'd1;
          end
        end else begin
          batch_o.item[n] = mk_value(text_char_i);
          n = n + 2'd1;
        end
      end
      PH_ESC: begin
        phase_d = PH_VALUE;
        case (text_char_i)
          CH_QUOTE:   batch_o.item[0] = mk_value(CH_QUOTE);
          CH_BSLASH:  batch_o.item[0] = mk_value(CH_BSLASH);
          CH_SLASH:   batch_o.item[0] = mk_value(CH_SLASH);
          CH_LOWER_N: batch_o.item[0] = mk_value(CH_LF);
          CH_LOWER_T: batch_o.item[0] = mk_value(CH_TAB);
          CH_LOWER_R: batch_o.item[0] = mk_value(CH_CR);
          default: begin
            // unknown escape: pass both characters through
            batch_o.item[0] = mk_value(CH_BSLASH);
            batch_o.item[1] = mk_value(text_char_i);
            n = 2'd1;
          end
        endcase
        n = n + 2'd1;
      end
      default: ;
    endcase

    if (end_of_body_i) begin
      case (phase_d)
        PH_SEARCH:                batch_o.item[n] = mk_status(ST_ABSENT, 1'b1);
        PH_SEP1, PH_SEP2, PH_BAD: batch_o.item[n] = mk_status(ST_MALFORMED, 1'b1);
        PH_VALUE, PH_ESC:         batch_o.item[n] = mk_status(ST_UNTERM, 1'b1);
        default:                  batch_o.item[n] = mk_status(ST_FOUND, 1'b1);
      endcase
      n        = n + 2'd1;
      phase_d  = PH_SEARCH;
      recent_d = '0;
      seen_d   = '0;
    end
    batch_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      recent_q <= '0;
      seen_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      recent_q <= recent_d;
      seen_q   <= seen_d;
    end
  end

  // Body end always leaves a clean search state
  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_body_i |=> (phase_q == PH_SEARCH) && (seen_q == '0))
    else $error("state not cleared after body end");

  // Every body end produces at least its status beat
  a_eob_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_body_i |-> (batch_o.count != 2'd0) &&
    batch_o.item[batch_o.count - 2'd1].is_final)
    else $error("body end without final status");

  // Key search emits nothing before the body ends
  a_search_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !end_of_body_i && (phase_q == PH_SEARCH) |-> batch_o.count == 2'd0)
    else $error("beat emitted during key search");

endmodule

`default_nettype wire

@@ src/jsfx_outq.sv @@
// ----------------------------------------------------------------------------
// jsfx_outq: result queue
// Four-slot shift queue; takes up to three beats at once, sends one a cycle while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfx_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsfx_pkg::batch_t batch_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output jsfx_pkg::res_t   data_o
);
  import jsfx_pkg::*;

  res_t [OQ_DEPTH-1:0] slot_q, slot_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d, base;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[0];
  assign pop     = valid_o && ready_i;
  // room for a full batch
  assign room_o  = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - MAX_RES));
  assign base    = cnt_q - OQ_CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      if (pop && (i < OQ_DEPTH - 1)) slot_d[i] = slot_q[(i + 1) % OQ_DEPTH];
      else                           slot_d[i] = slot_q[i];
      for (int j = 0; j < MAX_RES; j++) begin
        if (push_i && (2'(j) < batch_i.count) && (base + OQ_CNT_W'(j) == OQ_CNT_W'(i))) begin
          slot_d[i] = batch_i.item[j];
        end
      end
    end
    cnt_d = base + (push_i ? OQ_CNT_W'(batch_i.count) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("queue count over depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push without room");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i && !pop |=> cnt_q == $past(cnt_q))
    else $error("count moved without push or pop");

endmodule

`default_nettype wire
